[design/wtlf_pkg.sv]
// Shared types and constants of the weighted two-parameter line fit.
package wtlf_pkg;

  // Working width of the solver datapath; holds every exact intermediate.
  localparam int W = 208;

  // Sum indexes.
  localparam logic [2:0] T_LL = 3'd0;
  localparam logic [2:0] T_VV = 3'd1;
  localparam logic [2:0] T_VL = 3'd2;
  localparam logic [2:0] T_AV = 3'd3;
  localparam logic [2:0] T_AL = 3'd4;
  localparam logic [2:0] T_AA = 3'd5;

  // Scale factors of the solve.
  localparam logic [63:0] K_ANG  = 64'd1600000;
  localparam logic [63:0] K_VTX  = 64'd1048576;
  localparam logic [63:0] K_ASIG = 64'd104857600000000;
  localparam logic [63:0] K_VSIG = 64'h0010_0000_0000_0000;
  localparam logic [63:0] K_CHI  = 64'd1600;
  localparam logic [63:0] K_D100 = 64'd100;

  // Step counts of the shared unit.
  localparam logic [7:0] MAC_STEPS  = 8'd64;
  localparam logic [7:0] NDIV_STEPS = 8'd64;
  localparam logic [7:0] SQRT_STEPS = 8'd32;

  typedef enum logic [1:0] {
    OP_MAC  = 2'd0,
    OP_DIV  = 2'd1,
    OP_SQRT = 2'd2
  } alu_op_e;

  typedef struct packed {
    logic          valid;
    alu_op_e       op;
    logic          sub;
    logic          narrow;
    logic [W-1:0]  a;
    logic [63:0]   b;
    logic [W-1:0]  c;
  } alu_req_t;

  typedef struct packed {
    logic          done;
    logic [W-1:0]  res;
  } alu_rsp_t;

  typedef struct packed {
    logic signed [23:0] pos_x;
    logic [15:0]        sigma_x;
    logic signed [19:0] len_x;
    logic signed [15:0] mag_x;
    logic signed [23:0] pos_y;
    logic [15:0]        sigma_y;
    logic signed [19:0] len_y;
    logic signed [15:0] mag_y;
    logic               last_hit;
  } hit_t;

  typedef struct packed {
    logic               axis;
    logic signed [31:0] angle;
    logic signed [31:0] vertex;
    logic [31:0]        angle_sigma;
    logic [31:0]        vertex_sigma;
    logic [31:0]        chi_square;
    logic [3:0]         dof;
    logic               singular;
    logic               last_result;
  } res_t;

  function automatic logic [W-1:0] sx64(input logic [63:0] v);
    return {{(W-64){v[63]}}, v};
  endfunction

endpackage

[design/weighted_two_param_line_fit_core.sv]
// Top level of the weighted two-parameter line fit: hit accumulation and 2x2 solve.
//
// Usage
// - Request channel: a hit request is taken at a rising edge with start high
//   and busy low. Each hit carries x and y position, sigma, length and
//   magnification; last_hit closes the set and starts the solve.
// - Result channel: res_strobe_o marks result_o for exactly one cycle. A solve
//   gives two results, x first (axis 0) and then y (last_result set). The
//   receiver cannot stall; each result must be taken in its strobe cycle.
// - All multiplies, divides and square roots run on one shared iterative unit
//   (wtlf_alu) that does one multiplier bit, quotient bit or root bit per cycle,
//   under a sequencer.
// - Per hit: 2 squares plus 6 multiply/divide pairs per axis, with busy high.
//   A hit beyond MAX_HITS is not accumulated (it starts the solve if it is
//   the last).
// - A singular axis ends early with all value fields and dof zero.
// - After the y result the sums and hit count clear and busy drops.
// - Reset (rst_ni low, asynchronous) clears sums, hit count and sequencer;
//   the block is ready in the first cycle after reset.
module weighted_two_param_line_fit_core import wtlf_pkg::*; #(
  parameter int MAX_HITS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  input  hit_t hit_i,
  output logic busy,
  output logic res_strobe_o,
  output res_t result_o
);

  localparam int CW = ($clog2(MAX_HITS + 1) > 4) ? $clog2(MAX_HITS + 1) : 4;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SQ    = 3'd1;
  localparam logic [2:0] ST_MUL   = 3'd2;
  localparam logic [2:0] ST_DIV   = 3'd3;
  localparam logic [2:0] ST_SOLVE = 3'd4;

  // solve program steps
  localparam logic [4:0] SP_D0  = 5'd0;
  localparam logic [4:0] SP_D1  = 5'd1;
  localparam logic [4:0] SP_NA0 = 5'd2;
  localparam logic [4:0] SP_NA1 = 5'd3;
  localparam logic [4:0] SP_NB0 = 5'd4;
  localparam logic [4:0] SP_NB1 = 5'd5;
  localparam logic [4:0] SP_X0  = 5'd6;
  localparam logic [4:0] SP_X1  = 5'd7;
  localparam logic [4:0] SP_X2  = 5'd8;
  localparam logic [4:0] SP_X3  = 5'd9;
  localparam logic [4:0] SP_CHI = 5'd10;
  localparam logic [4:0] SP_A0  = 5'd11;
  localparam logic [4:0] SP_ANG = 5'd12;
  localparam logic [4:0] SP_V0  = 5'd13;
  localparam logic [4:0] SP_VTX = 5'd14;
  localparam logic [4:0] SP_AS0 = 5'd15;
  localparam logic [4:0] SP_ASD = 5'd16;
  localparam logic [4:0] SP_ASQ = 5'd17;
  localparam logic [4:0] SP_U   = 5'd18;
  localparam logic [4:0] SP_VS0 = 5'd19;
  localparam logic [4:0] SP_VSD = 5'd20;
  localparam logic [4:0] SP_VSQ = 5'd21;

  logic [2:0]    state_q;
  logic          pend_q;
  logic          axis_q;
  logic [2:0]    term_q;
  logic [4:0]    step_q;
  logic [CW-1:0] cnt_q;
  logic [63:0]   sums_q [2][6];
  logic          str_q;

  hit_t          hit_q;
  logic [31:0]   s2_q;
  logic [63:0]   prod_q;
  logic [W-1:0]  d_q, na_q, nb_q, t_q, u_q;
  res_t          res_q;

  alu_req_t      req;
  alu_rsp_t      alu_rsp;

  wtlf_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (alu_rsp)
  );

  function automatic logic [31:0] sat_s32(input logic [W-1:0] q, input logic neg);
    logic big;
    big = |q[W-1:32];
    if (!neg) return (big || q[31]) ? 32'h7FFF_FFFF : q[31:0];
    if (big || (q[31] && (|q[30:0]))) return 32'h8000_0000;
    return 32'h0 - q[31:0];
  endfunction

  function automatic logic [31:0] sat_u32(input logic [W-1:0] q);
    return (|q[W-1:32]) ? 32'hFFFF_FFFF : q[31:0];
  endfunction

  // per-hit operands of the selected axis
  logic [23:0] pos;
  logic [15:0] sig, sigf;
  logic [19:0] len;
  logic [15:0] mag;
  logic [23:0] opx, opy, fa, fb;
  logic [4:0]  sh;
  logic        hneg;
  logic [63:0] cur;
  logic [64:0] qv, addv, ssum;
  logic [63:0] sat_v;

  always_comb begin
    pos  = axis_q ? hit_q.pos_y   : hit_q.pos_x;
    sig  = axis_q ? hit_q.sigma_y : hit_q.sigma_x;
    len  = axis_q ? hit_q.len_y   : hit_q.len_x;
    mag  = axis_q ? hit_q.mag_y   : hit_q.mag_x;
    sigf = (sig == 16'd0) ? 16'd1 : sig;
    unique case (term_q)
      T_LL: begin
        opx = {{4{len[19]}}, len}; opy = {{4{len[19]}}, len}; sh = 5'd20;
      end
      T_VV: begin
        opx = {{8{mag[15]}}, mag}; opy = {{8{mag[15]}}, mag}; sh = 5'd28;
      end
      T_VL: begin
        opx = {{8{mag[15]}}, mag}; opy = {{4{len[19]}}, len}; sh = 5'd24;
      end
      T_AV: begin
        opx = pos; opy = {{8{mag[15]}}, mag}; sh = 5'd20;
      end
      T_AL: begin
        opx = pos; opy = {{4{len[19]}}, len}; sh = 5'd16;
      end
      default: begin
        opx = pos; opy = pos; sh = 5'd12;
      end
    endcase
    fa   = opx[23] ? (24'd0 - opx) : opx;
    fb   = opy[23] ? (24'd0 - opy) : opy;
    hneg = opx[23] ^ opy[23];
    // saturating accumulate of the signed weighted term
    cur   = sums_q[axis_q][term_q];
    qv    = {6'b0, alu_rsp.res[58:0]};
    addv  = hneg ? (65'd0 - qv) : qv;
    ssum  = {cur[63], cur} + addv;
    sat_v = (ssum[64] != ssum[63]) ?
            (ssum[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF) : ssum[63:0];
  end

  // solve-side operands
  logic [63:0] s_ll, s_vv, s_vl, s_av, s_al, s_aa;
  logic        fin, sing_w, asq_need, vsq_need, emit, emit_sing;
  logic [CW-1:0] dm;
  logic [3:0]  dof_v;

  always_comb begin
    s_ll = sums_q[axis_q][T_LL];
    s_vv = sums_q[axis_q][T_VV];
    s_vl = sums_q[axis_q][T_VL];
    s_av = sums_q[axis_q][T_AV];
    s_al = sums_q[axis_q][T_AL];
    s_aa = sums_q[axis_q][T_AA];
    fin      = alu_rsp.done && (state_q == ST_SOLVE);
    sing_w   = (cnt_q < CW'(2)) || alu_rsp.res[W-1] || (alu_rsp.res == '0);
    asq_need = !t_q[W-1] && !(|alu_rsp.res[W-1:64]);
    vsq_need = asq_need;
    emit_sing = (step_q == SP_D1);
    emit = fin && (((step_q == SP_D1) && sing_w) ||
                   ((step_q == SP_VSD) && !vsq_need) || (step_q == SP_VSQ));
    dm    = cnt_q - CW'(2);
    dof_v = (dm > CW'(15)) ? 4'd15 : dm[3:0];
  end

  // request to the shared unit
  always_comb begin
    req        = '0;
    req.valid  = (state_q != ST_IDLE) && !pend_q;
    req.op     = OP_MAC;
    unique case (state_q)
      ST_SQ: begin
        req.a = W'(sigf);
        req.b = 64'(sigf);
      end
      ST_MUL: begin
        req.a = W'(fa);
        req.b = 64'(fb) << sh;
      end
      ST_DIV: begin
        req.op     = OP_DIV;
        req.narrow = 1'b1;
        req.a      = W'(prod_q);
        req.c      = W'(s2_q);
      end
      ST_SOLVE: begin
        unique case (step_q)
          SP_D0:  begin req.a = sx64(s_vv); req.b = s_ll; end
          SP_D1:  begin req.a = sx64(s_vl); req.b = s_vl; req.c = t_q; req.sub = 1'b1; end
          SP_NA0: begin req.a = sx64(s_vv); req.b = s_al; end
          SP_NA1: begin req.a = sx64(s_av); req.b = s_vl; req.c = t_q; req.sub = 1'b1; end
          SP_NB0: begin req.a = sx64(s_ll); req.b = s_av; end
          SP_NB1: begin req.a = sx64(s_al); req.b = s_vl; req.c = t_q; req.sub = 1'b1; end
          SP_X0:  begin req.a = d_q; req.b = s_aa; end
          SP_X1:  begin req.a = na_q; req.b = s_al; req.c = t_q; req.sub = 1'b1; end
          SP_X2:  begin req.a = nb_q; req.b = s_av; req.c = t_q; req.sub = 1'b1; end
          SP_X3:  begin req.a = t_q; req.b = K_CHI; end
          SP_A0:  begin req.a = na_q; req.b = na_q[W-1] ? (64'd0 - K_ANG) : K_ANG; end
          SP_V0:  begin req.a = nb_q; req.b = nb_q[W-1] ? (64'd0 - K_VTX) : K_VTX; end
          SP_AS0: begin req.a = sx64(s_vv); req.b = K_ASIG; end
          SP_U:   begin req.a = d_q; req.b = K_D100; end
          SP_VS0: begin req.a = sx64(s_ll); req.b = K_VSIG; end
          SP_CHI, SP_ANG, SP_VTX, SP_ASD: begin
            req.op = OP_DIV; req.a = t_q; req.c = d_q;
          end
          SP_VSD: begin req.op = OP_DIV; req.a = t_q; req.c = u_q; end
          SP_ASQ, SP_VSQ: begin req.op = OP_SQRT; req.a = t_q; end
          default: begin req.valid = 1'b0; end
        endcase
      end
      default: begin req.valid = 1'b0; end
    endcase
  end

  // sequencer and accumulated state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pend_q  <= 1'b0;
      axis_q  <= 1'b0;
      term_q  <= T_LL;
      step_q  <= SP_D0;
      cnt_q   <= '0;
      str_q   <= 1'b0;
      for (int a = 0; a < 2; a++) begin
        for (int k = 0; k < 6; k++) begin
          sums_q[a][k] <= '0;
        end
      end
    end else begin
      str_q <= emit;
      if (req.valid) begin
        pend_q <= 1'b1;
      end else if (alu_rsp.done) begin
        pend_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (start) begin
            axis_q <= 1'b0;
            step_q <= SP_D0;
            if (cnt_q < CW'(MAX_HITS)) begin
              state_q <= ST_SQ;
            end else if (hit_i.last_hit) begin
              state_q <= ST_SOLVE;
            end
          end
        end
        ST_SQ: begin
          if (alu_rsp.done) begin
            term_q  <= T_LL;
            state_q <= ST_MUL;
          end
        end
        ST_MUL: begin
          if (alu_rsp.done) state_q <= ST_DIV;
        end
        ST_DIV: begin
          if (alu_rsp.done) begin
            sums_q[axis_q][term_q] <= sat_v;
            if (term_q == T_AA) begin
              if (!axis_q) begin
                axis_q  <= 1'b1;
                state_q <= ST_SQ;
              end else begin
                cnt_q  <= cnt_q + CW'(1);
                axis_q <= 1'b0;
                step_q <= SP_D0;
                state_q <= hit_q.last_hit ? ST_SOLVE : ST_IDLE;
              end
            end else begin
              term_q  <= term_q + 3'd1;
              state_q <= ST_MUL;
            end
          end
        end
        ST_SOLVE: begin
          if (fin) begin
            if (emit) begin
              if (!axis_q) begin
                axis_q <= 1'b1;
                step_q <= SP_D0;
              end else begin
                axis_q  <= 1'b0;
                cnt_q   <= '0;
                state_q <= ST_IDLE;
                for (int a = 0; a < 2; a++) begin
                  for (int k = 0; k < 6; k++) begin
                    sums_q[a][k] <= '0;
                  end
                end
              end
            end else if (step_q == SP_ASD) begin
              step_q <= asq_need ? SP_ASQ : SP_U;
            end else if (step_q == SP_VSD) begin
              step_q <= SP_VSQ;
            end else begin
              step_q <= step_q + 5'd1;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if ((state_q == ST_IDLE) && start) hit_q <= hit_i;
    if (alu_rsp.done && (state_q == ST_SQ))  s2_q   <= alu_rsp.res[31:0];
    if (alu_rsp.done && (state_q == ST_MUL)) prod_q <= alu_rsp.res[63:0];
    if (fin) begin
      unique case (step_q)
        SP_D1:  d_q  <= alu_rsp.res;
        SP_NA1: na_q <= alu_rsp.res;
        SP_NB1: nb_q <= alu_rsp.res;
        SP_U:   u_q  <= alu_rsp.res;
        SP_D0, SP_NA0, SP_NB0, SP_X0, SP_X1, SP_X2, SP_X3, SP_A0, SP_V0, SP_AS0, SP_VS0:
          t_q <= alu_rsp.res;
        SP_CHI: res_q.chi_square <= t_q[W-1] ? 32'd0 : sat_u32(alu_rsp.res);
        SP_ANG: res_q.angle  <= sat_s32(alu_rsp.res, na_q[W-1]);
        SP_VTX: res_q.vertex <= sat_s32(alu_rsp.res, nb_q[W-1]);
        SP_ASD: begin
          if (t_q[W-1]) res_q.angle_sigma <= 32'd0;
          else if (!asq_need) res_q.angle_sigma <= 32'hFFFF_FFFF;
          else t_q <= alu_rsp.res;
        end
        SP_ASQ: res_q.angle_sigma <= alu_rsp.res[31:0];
        SP_VSD: begin
          if (t_q[W-1]) res_q.vertex_sigma <= 32'd0;
          else if (!vsq_need) res_q.vertex_sigma <= 32'hFFFF_FFFF;
          else t_q <= alu_rsp.res;
        end
        SP_VSQ: res_q.vertex_sigma <= alu_rsp.res[31:0];
        default: t_q <= t_q;
      endcase
    end
    if (emit) begin
      res_q.axis        <= axis_q;
      res_q.last_result <= axis_q;
      res_q.singular    <= emit_sing;
      res_q.dof         <= emit_sing ? 4'd0 : dof_v;
      if (emit_sing) begin
        res_q.angle        <= '0;
        res_q.vertex       <= '0;
        res_q.angle_sigma  <= '0;
        res_q.vertex_sigma <= '0;
        res_q.chi_square   <= '0;
      end
    end
  end

  assign busy         = (state_q != ST_IDLE);
  assign res_strobe_o = str_q;
  assign result_o     = res_q;

  // the shared unit only answers an outstanding request
  a_done_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alu_rsp.done |-> pend_q)
    else $error("shared unit answered without a request");

  // results never come back to back
  a_strobe_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o |=> !res_strobe_o)
    else $error("result strobe held two cycles");

  // after the y result the block is idle with a cleared hit count
  a_pair_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_strobe_o && result_o.last_result) |-> (!busy && (cnt_q == '0)))
    else $error("block not cleared after final result");

  // a singular result carries zero fields
  a_sing_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_strobe_o && result_o.singular) |->
      ((result_o.angle == 0) && (result_o.dof == 0) && (result_o.chi_square == 0)))
    else $error("singular result with nonzero fields");

endmodule

[design/wtlf_alu.sv]
// Shared iterative unit: multiply-accumulate, restoring divide, integer square root.
module wtlf_alu import wtlf_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  alu_req_t req_i,
  output alu_rsp_t rsp_o
);

  logic          busy_q;
  logic          done_q;
  logic [7:0]    cnt_q;
  alu_op_e       op_q;
  logic          sub_q;
  logic          narrow_q;
  logic [W-1:0]  opa_q;
  logic [63:0]   opb_q;
  logic [W-1:0]  opc_q;
  logic [W-1:0]  acc_q;
  logic [W-1:0]  rem_q;

  logic [W-1:0]  lhs, rhs, trial;
  logic          sb, nbit, ge;
  logic [W:0]    sum;
  logic [35:0]   rsh, rtr;
  logic [7:0]    steps;

  always_comb begin
    nbit  = narrow_q ? opa_q[63] : opa_q[W-1];
    trial = {rem_q[W-2:0], nbit};
    rsh   = {rem_q[33:0], opa_q[63:62]};
    rtr   = {2'b00, acc_q[31:0], 2'b01};
    unique case (op_q)
      OP_MAC: begin
        lhs = acc_q;
        rhs = opb_q[0] ? opa_q : '0;
        // top multiplier bit carries negative weight
        sb  = sub_q ^ (cnt_q == 8'd1);
      end
      OP_DIV: begin
        lhs = trial;
        rhs = opc_q;
        sb  = 1'b1;
      end
      OP_SQRT: begin
        lhs = W'(rsh);
        rhs = W'(rtr);
        sb  = 1'b1;
      end
      default: begin
        lhs = '0;
        rhs = '0;
        sb  = 1'b0;
      end
    endcase
    sum = {1'b0, lhs} + ({1'b0, rhs} ^ {(W+1){sb}}) + {{W{1'b0}}, sb};
    ge  = ~sum[W];
    unique case (req_i.op)
      OP_MAC:  steps = MAC_STEPS;
      OP_DIV:  steps = req_i.narrow ? NDIV_STEPS : 8'(W);
      OP_SQRT: steps = SQRT_STEPS;
      default: steps = 8'd1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (!busy_q) begin
        if (req_i.valid) begin
          busy_q <= 1'b1;
          cnt_q  <= steps;
        end
      end else begin
        cnt_q <= cnt_q - 8'd1;
        if (cnt_q == 8'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!busy_q) begin
      if (req_i.valid) begin
        op_q     <= req_i.op;
        sub_q    <= req_i.sub;
        narrow_q <= req_i.narrow;
        opa_q    <= req_i.a;
        opb_q    <= req_i.b;
        opc_q    <= req_i.c;
        acc_q    <= (req_i.op == OP_MAC) ? req_i.c : '0;
        rem_q    <= '0;
      end
    end else begin
      unique case (op_q)
        OP_MAC: begin
          acc_q <= sum[W-1:0];
          opa_q <= {opa_q[W-2:0], 1'b0};
          opb_q <= {1'b0, opb_q[63:1]};
        end
        OP_DIV: begin
          rem_q <= ge ? sum[W-1:0] : trial;
          acc_q <= {acc_q[W-2:0], ge};
          opa_q <= {opa_q[W-2:0], 1'b0};
        end
        OP_SQRT: begin
          rem_q <= ge ? W'(sum[35:0]) : W'(rsh);
          acc_q <= {acc_q[W-2:0], ge};
          opa_q <= {opa_q[W-3:0], 2'b00};
        end
        default: begin
          acc_q <= acc_q;
        end
      endcase
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.res  = acc_q;

endmodule
